@@ rtl/fxhe_pkg.sv @@
// Package for the Chimp128 float XOR history encoder.
// Request and response structs, sizes and header codes; no dependencies.
package fxhe_pkg;
   localparam int HISTORY_LOG2_DEF = 7;
   localparam int INDEX_BITS_DEF   = 32;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_CLOSE  = 1'b1;

   localparam logic [63:0] END_MARKER   = 64'h7FF8_0000_0000_0000;
   localparam logic [6:0]  NO_LEADING   = 7'd127;
   localparam logic [6:0]  RESET_LEAD   = 7'd65;

   typedef struct packed {
      logic        cmd;
      logic [63:0] value_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] chunk_bits;
      logic [6:0]  chunk_len;
      logic        last;
   } rsp_type;

   // Work handed from front to back: the value plus close flag.
   typedef struct packed {
      logic        close;
      logic [63:0] value;
   } job_type;

   function automatic logic [2:0] lead_code(input logic [6:0] lz);
      logic [2:0] c;
      if (lz < 7'd8) c = 3'd0;
      else if (lz < 7'd12) c = 3'd1;
      else if (lz < 7'd16) c = 3'd2;
      else if (lz < 7'd18) c = 3'd3;
      else if (lz < 7'd20) c = 3'd4;
      else if (lz < 7'd22) c = 3'd5;
      else if (lz < 7'd24) c = 3'd6;
      else c = 3'd7;
      return c;
   endfunction

   function automatic logic [6:0] lead_round(input logic [2:0] c);
      logic [6:0] r;
      case (c)
         3'd0: r = 7'd0;
         3'd1: r = 7'd8;
         3'd2: r = 7'd12;
         3'd3: r = 7'd16;
         3'd4: r = 7'd18;
         3'd5: r = 7'd20;
         3'd6: r = 7'd22;
         default: r = 7'd24;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] count_lead(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = 7'(63 - i);
      end
      return n;
   endfunction

   function automatic logic [6:0] count_trail(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (x[i]) n = 7'(i);
      end
      return n;
   endfunction

   function automatic logic [63:0] fit(input logic [63:0] v, input logic [6:0] len);
      logic [63:0] m;
      m = (len >= 7'd64) ? '1 : ((64'd1 << len[5:0]) - 64'd1);
      return v & m;
   endfunction
endpackage

@@ rtl/fxhe_front.sv @@
// Front end: accepts requests, maps close to the end marker, queues jobs.
// Depends on fxhe_pkg.
module fxhe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fxhe_pkg::req_type  req_data,
   output logic               job_valid,
   input  logic               job_take,
   output fxhe_pkg::job_type  job_data
);
   // Two-entry queue
   fxhe_pkg::job_type q_ff [2];
   fxhe_pkg::job_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = job_take && job_valid;
   assign job_valid = (cnt_ff != 2'd0);
   assign job_data  = q_ff[rd_ff];

   always_comb begin
      q_in.close = (req_data.cmd == fxhe_pkg::CMD_CLOSE);
      q_in.value = q_in.close ? fxhe_pkg::END_MARKER : req_data.value_bits;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end
endmodule

@@ rtl/fxhe_back.sv @@
// Back end: hash lookup, history reference, case coding, chunk output.
// Depends on fxhe_pkg. Holds the hash and history memories.
module fxhe_back #(
   parameter int HISTORY_LOG2 = fxhe_pkg::HISTORY_LOG2_DEF,
   parameter int INDEX_BITS   = fxhe_pkg::INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_take,
   input  fxhe_pkg::job_type  job_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fxhe_pkg::rsp_type  rsp_data
);
   localparam int RING     = 1 << HISTORY_LOG2;
   localparam int KEY_BITS = HISTORY_LOG2 + 7;
   localparam int KEYS     = 1 << KEY_BITS;
   localparam int TZ_LIMIT = 6 + HISTORY_LOG2;
   localparam int HDR01    = HISTORY_LOG2 + 11;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_HDR   = 3'd3;
   localparam logic [2:0] ST_PAY   = 3'd4;
   localparam logic [2:0] ST_PAD   = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;

   logic [INDEX_BITS-1:0]   hash_mem [KEYS];
   logic [63:0]             hist_mem [RING];

   logic [2:0]              st_ff, st_in;
   logic [KEY_BITS-1:0]     clr_ff, clr_in;
   logic [INDEX_BITS-1:0]   pos_ff, pos_in;
   logic [HISTORY_LOG2-1:0] slot_ff, slot_in;
   logic [6:0]              keep_ff, keep_in;
   logic                    first_ff, first_in;
   logic [2:0]              phase_ff, phase_in;
   fxhe_pkg::job_type       job_ff;
   logic [INDEX_BITS-1:0]   cand_ff;
   logic [63:0]             prev_ff, hent_ff;
   logic [63:0]             hdr_b_ff, hdr_b_in, pay_b_ff, pay_b_in;
   logic [6:0]              hdr_l_ff, hdr_l_in, pay_l_ff, pay_l_in;
   logic                    ov_ff, ov_in;
   fxhe_pkg::rsp_type       out_ff, out_in;

   logic [KEY_BITS-1:0]     key;
   logic                    take, fire;
   logic [INDEX_BITS-1:0]   gap;
   logic [63:0]             x, hx;
   logic [6:0]              tz, lzr, sig;
   logic [2:0]              lc;
   logic                    use_hash;
   logic                    hw_en, mw_en;
   logic [KEY_BITS-1:0]     hw_addr;
   logic [INDEX_BITS-1:0]   hw_data;
   logic [HISTORY_LOG2-1:0] mw_addr;

   assign rsp_valid  = ov_ff;
   assign rsp_data   = out_ff;
   assign fire       = !ov_ff || !rsp_stall;
   assign take       = (st_ff == ST_IDLE) && job_valid;
   assign job_take   = take;
   assign key        = job_data.value[KEY_BITS-1:0];

   always_comb begin
      gap      = pos_ff - cand_ff;
      x        = job_ff.value ^ prev_ff;
      hx       = job_ff.value ^ hent_ff;
      tz       = fxhe_pkg::count_trail(hx);
      use_hash = (gap < INDEX_BITS'(RING)) && (tz > 7'(TZ_LIMIT));
      if (use_hash) x = hx;
      lc  = fxhe_pkg::lead_code(fxhe_pkg::count_lead(x));
      lzr = fxhe_pkg::lead_round(lc);
      sig = 7'(7'd64 - lzr - tz);

      st_in    = st_ff;
      clr_in   = clr_ff;
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      keep_in  = keep_ff;
      first_in = first_ff;
      phase_in = phase_ff;
      hdr_b_in = hdr_b_ff;
      hdr_l_in = hdr_l_ff;
      pay_b_in = pay_b_ff;
      pay_l_in = pay_l_ff;
      ov_in    = ov_ff && rsp_stall;
      out_in   = out_ff;
      hw_en    = 1'b0;
      hw_addr  = job_ff.value[KEY_BITS-1:0];
      hw_data  = pos_ff;
      mw_en    = 1'b0;
      mw_addr  = slot_ff;

      case (st_ff)
         ST_CLEAR: begin
            hw_en   = 1'b1;
            hw_addr = clr_ff;
            hw_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) st_in = ST_READ;
         end
         ST_READ: begin
            st_in = ST_CALC;
         end
         ST_CALC: begin
            pay_b_in = '0;
            pay_l_in = '0;
            if (first_ff) begin
               hdr_b_in = job_ff.value;
               hdr_l_in = 7'd64;
               first_in = 1'b0;
               hw_en = 1'b1;
               mw_en = 1'b1;
            end else begin
               if (x == '0) begin
                  hdr_b_in = 64'(use_hash ? cand_ff[HISTORY_LOG2-1:0] : slot_ff);
                  hdr_l_in = 7'(HISTORY_LOG2 + 2);
                  keep_in  = fxhe_pkg::RESET_LEAD;
               end else if (use_hash) begin
                  hdr_b_in = (64'(RING) + 64'(cand_ff[HISTORY_LOG2-1:0])) * 64'd512
                           + 64'd64 * 64'(lc) + 64'(sig);
                  hdr_l_in = 7'(HDR01);
                  pay_b_in = fxhe_pkg::fit(x >> tz[5:0], sig);
                  pay_l_in = sig;
                  keep_in  = fxhe_pkg::RESET_LEAD;
               end else if (lzr == keep_ff) begin
                  hdr_b_in = 64'd2;
                  hdr_l_in = 7'd2;
                  pay_b_in = x;
                  pay_l_in = 7'(7'd64 - lzr);
               end else begin
                  hdr_b_in = 64'd24 + 64'(lc);
                  hdr_l_in = 7'd5;
                  pay_b_in = x;
                  pay_l_in = 7'(7'd64 - lzr);
                  keep_in  = lzr;
               end
               slot_in = slot_ff + 1'b1;
               pos_in  = pos_ff + 1'b1;
               mw_en   = 1'b1;
               mw_addr = slot_in;
               hw_en   = 1'b1;
               hw_data = pos_in;
            end
            st_in = ST_HDR;
         end
         ST_HDR: begin
            if (fire) begin
               ov_in  = 1'b1;
               out_in.chunk_bits = fxhe_pkg::fit(hdr_b_ff, hdr_l_ff);
               out_in.chunk_len  = hdr_l_ff;
               out_in.last       = 1'b0;
               phase_in = phase_ff + hdr_l_ff[2:0];
               st_in = ST_PAY;
            end
         end
         ST_PAY: begin
            if (fire) begin
               ov_in  = 1'b1;
               out_in.chunk_bits = fxhe_pkg::fit(pay_b_ff, pay_l_ff);
               out_in.chunk_len  = pay_l_ff;
               out_in.last       = !job_ff.close;
               phase_in = phase_ff + pay_l_ff[2:0];
               st_in = job_ff.close ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            if (fire) begin
               ov_in  = 1'b1;
               out_in.chunk_bits = '0;
               out_in.chunk_len  = {4'd0, 3'(3'd0 - phase_ff)};
               out_in.last       = 1'b1;
               phase_in = '0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_CLEAR;
         clr_ff   <= '0;
         pos_ff   <= '0;
         slot_ff  <= '0;
         keep_ff  <= fxhe_pkg::NO_LEADING;
         first_ff <= 1'b1;
         phase_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         st_ff    <= st_in;
         clr_ff   <= clr_in;
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         keep_ff  <= keep_in;
         first_ff <= first_in;
         phase_ff <= phase_in;
         ov_ff    <= ov_in;
      end
      hdr_b_ff <= hdr_b_in;
      hdr_l_ff <= hdr_l_in;
      pay_b_ff <= pay_b_in;
      pay_l_ff <= pay_l_in;
      out_ff   <= out_in;
   end

   // Memories: hash and previous-value reads on accept, hashed ring slot read
   // in READ, registered data used in CALC. Writes of one item land in its
   // CALC cycle, well before the next accept.
   always_ff @(posedge clock) begin
      if (hw_en) hash_mem[hw_addr] <= hw_data;
      if (mw_en) hist_mem[mw_addr] <= job_ff.value;
      if (take) begin
         job_ff  <= job_data;
         cand_ff <= hash_mem[key];
         prev_ff <= hist_mem[slot_ff];
      end
      if (st_ff == ST_READ) hent_ff <= hist_mem[cand_ff[HISTORY_LOG2-1:0]];
   end
endmodule

@@ rtl/float_xor_history_encoder_unit.sv @@
// Top level of the Chimp128 float XOR history encoder.
// Depends on fxhe_pkg, fxhe_front and fxhe_back.
//
// Each encode transaction yields a header and a payload chunk; a close yields
// those plus a padding chunk. The back end steps through taking the job and
// reading the hash table and ring, the second history read, coding, then each
// chunk through the output register; a stalled output holds the back end.
// The two-entry front queue keeps accepting while the back end works, until
// it is full. After reset the back end sweeps the hash table, all
// 2^(HISTORY_LOG2+7) entries, before the first item is coded.
module float_xor_history_encoder_unit #(
   parameter int HISTORY_LOG2 = fxhe_pkg::HISTORY_LOG2_DEF,
   parameter int INDEX_BITS   = fxhe_pkg::INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fxhe_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fxhe_pkg::rsp_type  rsp_data
);
   logic              job_valid, job_take;
   fxhe_pkg::job_type job_data;

   fxhe_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid, .job_take, .job_data
   );

   fxhe_back #(.HISTORY_LOG2(HISTORY_LOG2), .INDEX_BITS(INDEX_BITS)) u_back (
      .clock, .reset, .job_valid, .job_take, .job_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

@@ rtl/fxhe_checker.sv @@
// Port-level checks for the encoder; bound to the top level.
// Depends on fxhe_pkg.
module fxhe_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fxhe_pkg::rsp_type rsp_data
);
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.chunk_len <= 7'd64) else $error("chunk_len over 64");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp changed");
   // bits above chunk_len are zero
   a_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.chunk_len >= 7'd64)
                    || ((rsp_data.chunk_bits >> rsp_data.chunk_len) == 64'd0))
      else $error("bits above chunk_len");
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp_valid after reset");
endmodule

bind float_xor_history_encoder_unit fxhe_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);
